FILE: rtl/accumulator_machine_execute_unit_defines.svh
// ----------------------------------------------------------------------------
// accumulator_machine_execute_unit_defines
// Assertion macros for the accumulator machine execute unit.
// ----------------------------------------------------------------------------
`ifndef ACCUMULATOR_MACHINE_EXECUTE_UNIT_DEFINES_SVH
`define ACCUMULATOR_MACHINE_EXECUTE_UNIT_DEFINES_SVH

// Implication check under synchronous reset
`define AMEU_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication check
`define AMEU_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

FILE: rtl/ameu_pkg.sv
// ----------------------------------------------------------------------------
// ameu_pkg
// Types, codes and sizes shared by the accumulator machine execute unit.
// ----------------------------------------------------------------------------
package ameu_pkg;

    localparam int NumVars   = 64;
    localparam int DataDepth = 256;
    localparam int ProgDepth = 1024;
    localparam int VarAw     = $clog2(NumVars);
    localparam int DataAw    = $clog2(DataDepth);
    localparam int DataCw    = DataAw + 1;
    localparam int PcW       = 11;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_EXEC   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [3:0] OPC_LOAD   = 4'd0;
    localparam logic [3:0] OPC_STORE  = 4'd1;
    localparam logic [3:0] OPC_IN     = 4'd2;
    localparam logic [3:0] OPC_OUT    = 4'd3;
    localparam logic [3:0] OPC_LINE   = 4'd4;
    localparam logic [3:0] OPC_PRINT  = 4'd5;
    localparam logic [3:0] OPC_ADD    = 4'd6;
    localparam logic [3:0] OPC_SUB    = 4'd7;
    localparam logic [3:0] OPC_MUL    = 4'd8;
    localparam logic [3:0] OPC_DIV    = 4'd9;
    localparam logic [3:0] OPC_JUMP   = 4'd10;
    localparam logic [3:0] OPC_JIZERO = 4'd11;
    localparam logic [3:0] OPC_JINEG  = 4'd12;
    localparam logic [3:0] OPC_HALT   = 4'd13;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_IMM   = 2'd1;
    localparam logic [1:0] KIND_NAMED = 2'd2;
    localparam logic [1:0] KIND_EMPTY = 2'd3;

    localparam logic [2:0] EV_NONE  = 3'd0;
    localparam logic [2:0] EV_INT   = 3'd1;
    localparam logic [2:0] EV_LINE  = 3'd2;
    localparam logic [2:0] EV_TEXT  = 3'd3;
    localparam logic [2:0] EV_HALT  = 3'd4;
    localparam logic [2:0] EV_ERROR = 3'd5;
    localparam logic [2:0] EV_END   = 3'd6;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_MISSING = 3'd1;
    localparam logic [2:0] ERR_NAME    = 3'd2;
    localparam logic [2:0] ERR_DATA    = 3'd3;
    localparam logic [2:0] ERR_DIVZERO = 3'd4;
    localparam logic [2:0] ERR_LABEL   = 3'd5;
    localparam logic [2:0] ERR_PRINT   = 3'd6;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [31:0] value;
        logic [7:0]  text_out;
        logic [2:0]  error_code;
        logic [10:0] next_pc;
        logic        data_full;
    } t_result;

endpackage

FILE: rtl/accumulator_machine_execute_unit.sv
// ----------------------------------------------------------------------------
// accumulator_machine_execute_unit
// Executes one accumulator machine instruction, data append or run clear per
// item, with the variable store and data section held in synchronous RAMs.
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// in       input      i_valid / o_ready    operation .. data_word
// out      output     o_valid / i_ready    event_res .. data_full
// cfg      input      i_cfg_valid / o_cfg_ready  program_length
//
// An item passes through issue with the RAM reads, then execute and
// write back. Divide iterates in S_DIV, a one-bit-per-cycle divider, then finishes in S_DFIN.
// Multiply passes through S_MUL for the registered product.
// Reset clears accumulator, pc, read pointer, data count, program length and valid bits.
// A new item is taken once the previous item has written back and its
// result leaves the output register.
// ----------------------------------------------------------------------------
`include "accumulator_machine_execute_unit_defines.svh"

module accumulator_machine_execute_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [3:0]  i_opcode,
    input  logic [1:0]  i_operand_kind,
    input  logic signed [31:0] i_immediate,
    input  logic [5:0]  i_var_index,
    input  logic        i_target_valid,
    input  logic [9:0]  i_target_index,
    input  logic [7:0]  i_text_id,
    input  logic signed [31:0] i_data_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_event_res,
    output logic signed [31:0] o_value,
    output logic [7:0]  o_text_out,
    output logic [2:0]  o_error_code,
    output logic [10:0] o_next_pc,
    output logic        o_data_full
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DFIN = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [31:0] r_acc, n_acc;
    logic [10:0] r_pc, n_pc;
    logic [ameu_pkg::DataCw-1:0] r_rdp, n_rdp, r_cnt, n_cnt;
    logic [ameu_pkg::NumVars-1:0] r_vvalid, n_vvalid;
    logic [10:0] r_plen;
    logic        r_oval, n_oval;
    ameu_pkg::t_result r_res, n_res;

    // latched item
    logic [1:0]  r_op;
    logic [3:0]  r_opc;
    logic [1:0]  r_kind;
    logic [31:0] r_imm;
    logic [ameu_pkg::VarAw-1:0] r_vidx;
    logic        r_tval;
    logic [9:0]  r_tidx;
    logic [7:0]  r_text;

    logic [31:0] var_mem [ameu_pkg::NumVars];
    logic [31:0] data_mem [ameu_pkg::DataDepth];
    logic [31:0] r_var_q, r_data_q;

    logic        in_acc, out_acc;
    logic        var_we, data_we;
    logic [ameu_pkg::DataAw-1:0] data_wa;

    // divider
    logic [31:0] r_dq, n_dq, r_drem, n_drem, r_dden, n_dden;
    logic [5:0]  r_dcnt, n_dcnt;
    logic        r_dneg, n_dneg;
    logic [31:0] r_prod, n_prod;
    logic [32:0] trial;
    logic [31:0] shrem;

    logic [31:0] opnd, am, bm;
    logic [10:0] len, pc_inc;
    logic        take, ok_vidx;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;
    assign o_ready = (r_state == S_IDLE) && (!r_oval || i_ready);
    assign o_cfg_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_var_q  <= var_mem[i_var_index[ameu_pkg::VarAw-1:0]];
            r_data_q <= data_mem[r_rdp[ameu_pkg::DataAw-1:0]];
        end
        if (var_we) begin
            var_mem[r_vidx] <= r_acc;
        end
        if (data_we) begin
            data_mem[data_wa] <= r_imm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op   <= i_operation;
            r_opc  <= i_opcode;
            r_kind <= i_operand_kind;
            r_imm  <= (i_operation == ameu_pkg::OP_APPEND) ? i_data_word : i_immediate;
            r_vidx <= i_var_index[ameu_pkg::VarAw-1:0];
            r_tval <= i_target_valid;
            r_tidx <= i_target_index;
            r_text <= i_text_id;
        end
        r_dq   <= n_dq;
        r_drem <= n_drem;
        r_dden <= n_dden;
        r_dcnt <= n_dcnt;
        r_dneg <= n_dneg;
        r_prod <= n_prod;
        r_res  <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_acc    <= '0;
            r_pc     <= '0;
            r_rdp    <= '0;
            r_cnt    <= '0;
            r_vvalid <= '0;
            r_plen   <= '0;
            r_oval   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_acc    <= n_acc;
            r_pc     <= n_pc;
            r_rdp    <= n_rdp;
            r_cnt    <= n_cnt;
            r_vvalid <= n_vvalid;
            r_oval   <= n_oval;
            if (i_cfg_valid && o_cfg_ready) begin
                r_plen <= i_cfg_data;
            end
        end
    end

    assign len = (r_plen > 11'(ameu_pkg::ProgDepth)) ? 11'(ameu_pkg::ProgDepth) : r_plen;
    assign pc_inc = r_pc + 11'd1;
    assign ok_vidx = (32'(r_vidx) < 32'(ameu_pkg::NumVars));
    assign data_wa = r_cnt[ameu_pkg::DataAw-1:0];
    assign am = r_acc[31] ? (32'd0 - r_acc) : r_acc;
    assign bm = opnd[31] ? (32'd0 - opnd) : opnd;
    assign shrem = {r_drem[30:0], r_dq[31]};
    assign trial = {1'b0, shrem} - {1'b0, r_dden};

    always_comb begin
        if (r_kind == ameu_pkg::KIND_IMM) begin
            opnd = r_imm;
        end else if (r_kind == ameu_pkg::KIND_NAMED && ok_vidx && r_vvalid[r_vidx]) begin
            opnd = r_var_q;
        end else begin
            opnd = '0;
        end
    end

    always_comb begin
        case (r_opc)
            ameu_pkg::OPC_JUMP:   take = 1'b1;
            ameu_pkg::OPC_JIZERO: take = (r_acc == 32'd0);
            ameu_pkg::OPC_JINEG:  take = r_acc[31];
            default:              take = 1'b0;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_acc    = r_acc;
        n_pc     = r_pc;
        n_rdp    = r_rdp;
        n_cnt    = r_cnt;
        n_vvalid = r_vvalid;
        n_oval   = r_oval && !i_ready;
        n_res    = r_res;
        n_dq     = r_dq;
        n_drem   = r_drem;
        n_dden   = r_dden;
        n_dcnt   = r_dcnt;
        n_dneg   = r_dneg;
        n_prod   = r_prod;
        var_we   = 1'b0;
        data_we  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_oval  = 1'b1;
                n_res   = '0;
                case (r_op)
                    ameu_pkg::OP_APPEND: begin
                        if (r_cnt < ameu_pkg::DataCw'(ameu_pkg::DataDepth)) begin
                            data_we = 1'b1;
                            n_cnt   = r_cnt + 1'b1;
                        end else begin
                            n_res.data_full = 1'b1;
                        end
                    end
                    ameu_pkg::OP_CLEAR: begin
                        n_acc    = '0;
                        n_pc     = '0;
                        n_rdp    = '0;
                        n_vvalid = '0;
                    end
                    ameu_pkg::OP_EXEC: begin
                        if (r_pc >= len) begin
                            n_res.event_res = ameu_pkg::EV_END;
                        end else begin
                            case (r_opc)
                                ameu_pkg::OPC_LOAD, ameu_pkg::OPC_ADD, ameu_pkg::OPC_SUB,
                                ameu_pkg::OPC_MUL, ameu_pkg::OPC_DIV: begin
                                    if (r_kind == ameu_pkg::KIND_NONE) begin
                                        n_res.error_code = ameu_pkg::ERR_MISSING;
                                    end else if (r_opc == ameu_pkg::OPC_DIV && opnd == '0) begin
                                        n_res.error_code = ameu_pkg::ERR_DIVZERO;
                                    end else if (r_opc == ameu_pkg::OPC_MUL) begin
                                        n_prod  = 32'(r_acc * opnd);
                                        n_oval  = r_oval && !i_ready;
                                        n_state = S_MUL;
                                    end else if (r_opc == ameu_pkg::OPC_DIV) begin
                                        n_dq    = am;
                                        n_drem  = '0;
                                        n_dden  = bm;
                                        n_dcnt  = '0;
                                        n_dneg  = r_acc[31] ^ opnd[31];
                                        n_oval  = r_oval && !i_ready;
                                        n_state = S_DIV;
                                    end else begin
                                        if (r_opc == ameu_pkg::OPC_LOAD) begin
                                            n_acc = opnd;
                                        end else if (r_opc == ameu_pkg::OPC_ADD) begin
                                            n_acc = r_acc + opnd;
                                        end else begin
                                            n_acc = r_acc - opnd;
                                        end
                                        n_pc = pc_inc;
                                    end
                                end
                                ameu_pkg::OPC_STORE: begin
                                    if (r_kind != ameu_pkg::KIND_NAMED) begin
                                        n_res.error_code = ameu_pkg::ERR_NAME;
                                    end else begin
                                        if (ok_vidx) begin
                                            var_we = 1'b1;
                                            n_vvalid[r_vidx] = 1'b1;
                                        end
                                        n_pc = pc_inc;
                                    end
                                end
                                ameu_pkg::OPC_IN: begin
                                    if (r_rdp >= r_cnt) begin
                                        n_res.error_code = ameu_pkg::ERR_DATA;
                                    end else begin
                                        n_acc = r_data_q;
                                        n_rdp = r_rdp + 1'b1;
                                        n_pc  = pc_inc;
                                    end
                                end
                                ameu_pkg::OPC_OUT: begin
                                    n_res.event_res = ameu_pkg::EV_INT;
                                    n_res.value     = r_acc;
                                    n_pc            = pc_inc;
                                end
                                ameu_pkg::OPC_LINE: begin
                                    n_res.event_res = ameu_pkg::EV_LINE;
                                    n_pc            = pc_inc;
                                end
                                ameu_pkg::OPC_PRINT: begin
                                    if (r_kind != ameu_pkg::KIND_NAMED &&
                                        r_kind != ameu_pkg::KIND_EMPTY) begin
                                        n_res.error_code = ameu_pkg::ERR_PRINT;
                                    end else begin
                                        n_res.event_res = ameu_pkg::EV_TEXT;
                                        n_res.text_out  = r_text;
                                        n_pc            = pc_inc;
                                    end
                                end
                                ameu_pkg::OPC_JUMP, ameu_pkg::OPC_JIZERO,
                                ameu_pkg::OPC_JINEG: begin
                                    if (r_kind != ameu_pkg::KIND_NAMED) begin
                                        n_res.error_code = ameu_pkg::ERR_NAME;
                                    end else if (!take) begin
                                        n_pc = pc_inc;
                                    end else if (!r_tval) begin
                                        n_res.error_code = ameu_pkg::ERR_LABEL;
                                    end else begin
                                        n_pc = {1'b0, r_tidx};
                                    end
                                end
                                ameu_pkg::OPC_HALT: begin
                                    n_res.event_res = ameu_pkg::EV_HALT;
                                    n_pc            = pc_inc;
                                end
                                default: begin
                                end
                            endcase
                            if (n_res.error_code != ameu_pkg::ERR_NONE) begin
                                n_res.event_res = ameu_pkg::EV_ERROR;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
                n_res.next_pc = n_pc;
            end
            S_MUL: begin
                n_acc         = r_prod;
                n_pc          = pc_inc;
                n_res.next_pc = pc_inc;
                n_oval        = 1'b1;
                n_state       = S_IDLE;
            end
            S_DIV: begin
                // one quotient bit per cycle, restoring
                if (!trial[32]) begin
                    n_drem = trial[31:0];
                    n_dq   = {r_dq[30:0], 1'b1};
                end else begin
                    n_drem = shrem;
                    n_dq   = {r_dq[30:0], 1'b0};
                end
                n_dcnt = r_dcnt + 6'd1;
                if (r_dcnt == 6'd31) begin
                    n_state = S_DFIN;
                end
            end
            S_DFIN: begin
                n_acc         = r_dneg ? (32'd0 - r_dq) : r_dq;
                n_pc          = pc_inc;
                n_res.next_pc = pc_inc;
                n_oval        = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid      = r_oval;
    assign o_event_res  = r_res.event_res;
    assign o_value      = r_res.value;
    assign o_text_out   = r_res.text_out;
    assign o_error_code = r_res.error_code;
    assign o_next_pc    = r_res.next_pc;
    assign o_data_full  = r_res.data_full;

    `AMEU_ASSERT_IMP(a_busy_no_accept, i_clk, i_rst_n, r_state != S_IDLE, !o_ready)
    `AMEU_ASSERT_NXT(a_accept_exec, i_clk, i_rst_n, in_acc, r_state == S_EXEC)
    `AMEU_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1,
        r_cnt <= ameu_pkg::DataCw'(ameu_pkg::DataDepth))
    `AMEU_ASSERT_IMP(a_err_event, i_clk, i_rst_n, o_valid && o_error_code != ameu_pkg::ERR_NONE,
        o_event_res == ameu_pkg::EV_ERROR)

endmodule
